// ===== rtl/pvl_pkg.sv =====
// pvl_pkg: shared types, sizes and codes for the pooled voice list
// used by pvl_free_fifo and pooled_voice_list
package pvl_pkg;

  localparam int SLOTS        = 64;
  localparam int PAYLOAD_BITS = 64;
  localparam int SLOT_W       = $clog2(SLOTS);
  localparam int LINK_W       = SLOT_W + 1;
  localparam int CNT_W        = $clog2(SLOTS + 1);

  typedef logic [SLOT_W-1:0]       slot_t;
  typedef logic [LINK_W-1:0]       link_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [PAYLOAD_BITS-1:0] pay_t;

  localparam link_t NONE_SLOT = LINK_W'(SLOTS);

  typedef enum logic [2:0] {
    CMD_ADD         = 3'd0,
    CMD_REMOVE      = 3'd1,
    CMD_REMOVE_LAST = 3'd2,
    CMD_CHECK       = 3'd3,
    CMD_READ        = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_FREE    = 2'd1,
    ST_NOT_LISTED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_WR,
    S_ADD_LINK,
    S_RM_RD,
    S_RM_LINK,
    S_RD_RD,
    S_RD_CAP,
    S_FIN
  } state_t;

  // free fifo control from the sequencer
  typedef struct packed {
    logic  pop;
    logic  push;
    slot_t push_slot;
  } free_ctl_t;

  // free fifo status to the sequencer
  typedef struct packed {
    logic  empty;
    slot_t head;
  } free_stat_t;

endpackage

// ===== rtl/pvl_ram.sv =====
// pvl_ram: generic single write port, single read port ram with registered read
// no dependencies
module pvl_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/pvl_free_fifo.sv =====
// pvl_free_fifo: circular fifo of free slot numbers, starts as 0..SLOTS-1
// entries never written read as their own index; depends on pvl_pkg
module pvl_free_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  pvl_pkg::free_ctl_t ctl,
  output pvl_pkg::free_stat_t stat
);

  pvl_pkg::slot_t            mem [pvl_pkg::SLOTS];
  logic [pvl_pkg::SLOTS-1:0] vld_r;
  pvl_pkg::slot_t            rd_ptr_r;
  pvl_pkg::slot_t            wr_ptr_r;
  pvl_pkg::cnt_t             cnt_r;
  pvl_pkg::slot_t            mem_q_r;
  logic                      vld_q_r;
  pvl_pkg::slot_t            ptr_q_r;

  function automatic pvl_pkg::slot_t wrap_inc(input pvl_pkg::slot_t p);
    if (p == pvl_pkg::SLOT_W'(pvl_pkg::SLOTS - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[wr_ptr_r] <= ctl.push_slot;
    end
    mem_q_r <= mem[rd_ptr_r];
    vld_q_r <= vld_r[rd_ptr_r];
    ptr_q_r <= rd_ptr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      cnt_r    <= pvl_pkg::CNT_W'(pvl_pkg::SLOTS);
    end else begin
      if (ctl.push) begin
        vld_r[wr_ptr_r] <= 1'b1;
        wr_ptr_r        <= wrap_inc(wr_ptr_r);
        cnt_r           <= cnt_r + 1'b1;
      end else if (ctl.pop) begin
        rd_ptr_r <= wrap_inc(rd_ptr_r);
        cnt_r    <= cnt_r - 1'b1;
      end
    end
  end

  assign stat.empty = (cnt_r == '0);
  assign stat.head  = vld_q_r ? mem_q_r : ptr_q_r;

endmodule

// ===== rtl/pooled_voice_list.sv =====
// pooled_voice_list: top level, command sequencer around the link and payload rams
// depends on pvl_pkg, pvl_ram and pvl_free_fifo
//
// A word is taken when start is high and busy is low; busy stays high until the
// command is done. Add does the ram writes and the free fifo pop in S_ADD_WR and
// links the old head in S_ADD_LINK; remove and remove-last do the registered ram
// read in S_RM_RD and the link update in S_RM_LINK; read does the registered ram
// read in S_RD_RD and the capture in S_RD_CAP; check and the error cases go to
// S_FIN sooner. Every command ends in S_FIN, which loads the result word. The
// result word shows on the out_ ports for exactly one cycle with out_valid high, in
// the cycle after the last step, and must be captured then: the block cannot be
// stalled by the receiver.
module pooled_voice_list (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [2:0]                      in_command,
  input  logic [pvl_pkg::SLOT_W-1:0]      in_slot,
  input  logic [63:0]                     in_payload,
  output logic                            out_valid,
  output logic [1:0]                      out_status,
  output logic [pvl_pkg::SLOT_W-1:0]      out_slot,
  output logic [63:0]                     out_payload,
  output logic [pvl_pkg::LINK_W-1:0]      out_next_slot,
  output logic [pvl_pkg::LINK_W-1:0]      out_prev_slot,
  output logic [pvl_pkg::LINK_W-1:0]      out_head_slot,
  output logic [pvl_pkg::LINK_W-1:0]      out_tail_slot,
  output logic [pvl_pkg::CNT_W-1:0]       out_count,
  output logic                            out_is_member
);

  pvl_pkg::state_t           state_r, state_nxt;
  pvl_pkg::slot_t            slot_r, slot_nxt;
  pvl_pkg::slot_t            tgt_r, tgt_nxt;
  pvl_pkg::pay_t             pay_r, pay_nxt;
  pvl_pkg::link_t            head_r, head_nxt;
  pvl_pkg::link_t            tail_r, tail_nxt;
  pvl_pkg::cnt_t             count_r, count_nxt;
  logic [pvl_pkg::SLOTS-1:0] in_use_r, in_use_nxt;
  pvl_pkg::status_t          status_r, status_nxt;
  pvl_pkg::slot_t            slot_o_r, slot_o_nxt;
  pvl_pkg::pay_t             pay_o_r, pay_o_nxt;
  pvl_pkg::link_t            nx_o_r, nx_o_nxt;
  pvl_pkg::link_t            pv_o_r, pv_o_nxt;

  logic                      out_valid_r;
  pvl_pkg::status_t          out_status_r;
  pvl_pkg::slot_t            out_slot_r;
  pvl_pkg::pay_t             out_payload_r;
  pvl_pkg::link_t            out_next_r;
  pvl_pkg::link_t            out_prev_r;
  pvl_pkg::link_t            out_head_r;
  pvl_pkg::link_t            out_tail_r;
  pvl_pkg::cnt_t             out_count_r;
  logic                      out_member_r;

  // count update unit
  logic                      cnt_inc;
  logic                      cnt_dec;

  logic                      pay_we;
  pvl_pkg::slot_t            pay_waddr;
  pvl_pkg::pay_t             pay_rdata;
  logic                      nxt_we;
  pvl_pkg::slot_t            nxt_waddr;
  pvl_pkg::link_t            nxt_wdata;
  pvl_pkg::link_t            nxt_rdata;
  logic                      prv_we;
  pvl_pkg::slot_t            prv_waddr;
  pvl_pkg::link_t            prv_wdata;
  pvl_pkg::link_t            prv_rdata;

  pvl_pkg::free_ctl_t        free_ctl;
  pvl_pkg::free_stat_t       free_stat;

  pvl_ram #(
    .DEPTH(pvl_pkg::SLOTS),
    .WIDTH(pvl_pkg::PAYLOAD_BITS)
  ) u_pay_ram (
    .clk   (clk),
    .we    (pay_we),
    .waddr (pay_waddr),
    .wdata (pay_r),
    .raddr (tgt_r),
    .rdata (pay_rdata)
  );

  pvl_ram #(
    .DEPTH(pvl_pkg::SLOTS),
    .WIDTH(pvl_pkg::LINK_W)
  ) u_next_ram (
    .clk   (clk),
    .we    (nxt_we),
    .waddr (nxt_waddr),
    .wdata (nxt_wdata),
    .raddr (tgt_r),
    .rdata (nxt_rdata)
  );

  pvl_ram #(
    .DEPTH(pvl_pkg::SLOTS),
    .WIDTH(pvl_pkg::LINK_W)
  ) u_prev_ram (
    .clk   (clk),
    .we    (prv_we),
    .waddr (prv_waddr),
    .wdata (prv_wdata),
    .raddr (tgt_r),
    .rdata (prv_rdata)
  );

  pvl_free_fifo u_free_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (free_ctl),
    .stat  (free_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= pvl_pkg::S_IDLE;
      head_r   <= pvl_pkg::NONE_SLOT;
      tail_r   <= pvl_pkg::NONE_SLOT;
      count_r  <= '0;
      in_use_r <= '0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      count_r  <= count_nxt;
      in_use_r <= in_use_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r   <= slot_nxt;
    tgt_r    <= tgt_nxt;
    pay_r    <= pay_nxt;
    status_r <= status_nxt;
    slot_o_r <= slot_o_nxt;
    pay_o_r  <= pay_o_nxt;
    nx_o_r   <= nx_o_nxt;
    pv_o_r   <= pv_o_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    slot_nxt   = slot_r;
    tgt_nxt    = tgt_r;
    pay_nxt    = pay_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    in_use_nxt = in_use_r;
    status_nxt = status_r;
    slot_o_nxt = slot_o_r;
    pay_o_nxt  = pay_o_r;
    nx_o_nxt   = nx_o_r;
    pv_o_nxt   = pv_o_r;
    cnt_inc    = 1'b0;
    cnt_dec    = 1'b0;
    pay_we     = 1'b0;
    pay_waddr  = free_stat.head;
    nxt_we     = 1'b0;
    nxt_waddr  = free_stat.head;
    nxt_wdata  = head_r;
    prv_we     = 1'b0;
    prv_waddr  = free_stat.head;
    prv_wdata  = pvl_pkg::NONE_SLOT;
    free_ctl   = '0;
    free_ctl.push_slot = tgt_r;

    unique case (state_r)
      pvl_pkg::S_IDLE: begin
        if (start) begin
          slot_nxt   = in_slot;
          tgt_nxt    = in_slot;
          pay_nxt    = in_payload[pvl_pkg::PAYLOAD_BITS-1:0];
          status_nxt = pvl_pkg::ST_OK;
          slot_o_nxt = '0;
          pay_o_nxt  = '0;
          nx_o_nxt   = pvl_pkg::NONE_SLOT;
          pv_o_nxt   = pvl_pkg::NONE_SLOT;
          state_nxt  = pvl_pkg::S_FIN;
          unique case (in_command)
            pvl_pkg::CMD_ADD: begin
              state_nxt = pvl_pkg::S_ADD_WR;
            end
            pvl_pkg::CMD_REMOVE: begin
              if (in_use_r[in_slot]) begin
                state_nxt = pvl_pkg::S_RM_RD;
              end else begin
                status_nxt = pvl_pkg::ST_NOT_LISTED;
              end
            end
            pvl_pkg::CMD_REMOVE_LAST: begin
              if (count_r == '0 || tail_r >= pvl_pkg::NONE_SLOT) begin
                status_nxt = pvl_pkg::ST_NOT_LISTED;
              end else begin
                tgt_nxt    = tail_r[pvl_pkg::SLOT_W-1:0];
                slot_o_nxt = tail_r[pvl_pkg::SLOT_W-1:0];
                state_nxt  = pvl_pkg::S_RM_RD;
              end
            end
            pvl_pkg::CMD_READ: begin
              if (in_use_r[in_slot]) begin
                state_nxt = pvl_pkg::S_RD_RD;
              end else begin
                status_nxt = pvl_pkg::ST_NOT_LISTED;
              end
            end
            default: begin
              state_nxt = pvl_pkg::S_FIN;
            end
          endcase
        end
      end

      pvl_pkg::S_ADD_WR: begin
        if (free_stat.empty) begin
          status_nxt = pvl_pkg::ST_NO_FREE;
          state_nxt  = pvl_pkg::S_FIN;
        end else begin
          tgt_nxt      = free_stat.head;
          pay_we       = 1'b1;
          nxt_we       = 1'b1;
          prv_we       = 1'b1;
          free_ctl.pop = 1'b1;
          state_nxt    = pvl_pkg::S_ADD_LINK;
        end
      end

      pvl_pkg::S_ADD_LINK: begin
        if (head_r < pvl_pkg::NONE_SLOT) begin
          prv_we    = 1'b1;
          prv_waddr = head_r[pvl_pkg::SLOT_W-1:0];
          prv_wdata = pvl_pkg::LINK_W'(tgt_r);
        end else begin
          tail_nxt = pvl_pkg::LINK_W'(tgt_r);
        end
        head_nxt          = pvl_pkg::LINK_W'(tgt_r);
        in_use_nxt[tgt_r] = 1'b1;
        cnt_inc           = 1'b1;
        slot_o_nxt        = tgt_r;
        state_nxt         = pvl_pkg::S_FIN;
      end

      pvl_pkg::S_RM_RD: begin
        state_nxt = pvl_pkg::S_RM_LINK;
      end

      pvl_pkg::S_RM_LINK: begin
        if (pvl_pkg::LINK_W'(tgt_r) == head_r) begin
          head_nxt = nxt_rdata;
        end else if (prv_rdata < pvl_pkg::NONE_SLOT) begin
          nxt_we    = 1'b1;
          nxt_waddr = prv_rdata[pvl_pkg::SLOT_W-1:0];
          nxt_wdata = nxt_rdata;
        end
        if (pvl_pkg::LINK_W'(tgt_r) == tail_r) begin
          tail_nxt = prv_rdata;
        end else if (nxt_rdata < pvl_pkg::NONE_SLOT) begin
          prv_we    = 1'b1;
          prv_waddr = nxt_rdata[pvl_pkg::SLOT_W-1:0];
          prv_wdata = prv_rdata;
        end
        in_use_nxt[tgt_r] = 1'b0;
        cnt_dec           = 1'b1;
        free_ctl.push     = 1'b1;
        state_nxt         = pvl_pkg::S_FIN;
      end

      pvl_pkg::S_RD_RD: begin
        state_nxt = pvl_pkg::S_RD_CAP;
      end

      pvl_pkg::S_RD_CAP: begin
        pay_o_nxt = pay_rdata;
        nx_o_nxt  = nxt_rdata;
        pv_o_nxt  = prv_rdata;
        state_nxt = pvl_pkg::S_FIN;
      end

      pvl_pkg::S_FIN: begin
        state_nxt = pvl_pkg::S_IDLE;
      end

      default: begin
        state_nxt = pvl_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (cnt_inc) begin
      count_nxt = count_r + 1'b1;
    end else if (cnt_dec) begin
      count_nxt = count_r - 1'b1;
    end else begin
      count_nxt = count_r;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == pvl_pkg::S_FIN);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == pvl_pkg::S_FIN) begin
      out_status_r  <= status_r;
      out_slot_r    <= slot_o_r;
      out_payload_r <= pay_o_r;
      out_next_r    <= nx_o_r;
      out_prev_r    <= pv_o_r;
      out_head_r    <= head_r;
      out_tail_r    <= tail_r;
      out_count_r   <= count_r;
      out_member_r  <= in_use_r[slot_r];
    end
  end

  assign busy          = (state_r != pvl_pkg::S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_slot      = out_slot_r;
  assign out_payload   = 64'(out_payload_r);
  assign out_next_slot = out_next_r;
  assign out_prev_slot = out_prev_r;
  assign out_head_slot = out_head_r;
  assign out_tail_slot = out_tail_r;
  assign out_count     = out_count_r;
  assign out_is_member = out_member_r;

endmodule
